// ===== src/qoa_pkg.sv =====
// Shared types and default sizes for the quaternion orientation accumulator.
// No dependencies; used by qoa_mac and the top level.
package qoa_pkg;

    localparam int COMP_BITS_DEFAULT = 16;
    localparam int FRAC_BITS_DEFAULT = 14;

    // Control that travels with one multiply through the shared MAC
    typedef struct packed {
        logic       first;      // start a new accumulation
        logic       last;       // accumulation complete after this term
        logic       phase_end;  // last term of the current sequencer phase
        logic       shift2;     // floor the product by two bits
        logic       dbl;        // add twice the product
        logic       neg;        // subtract instead of add
        logic       init_one;   // start from one in the squared fraction format
        logic [3:0] dst;        // destination slot of the finished sum
    } mac_tag_t;

    typedef struct packed {
        logic       done;
        logic       phase_end;
        logic [3:0] dst;
    } mac_stat_t;

endpackage

// ===== src/qoa_mac.sv =====
// Shared multiply-accumulate unit: one registered signed multiplier and an accumulator.
// Depends on qoa_pkg for the tag and status structs.
module qoa_mac #(
    parameter int MW = 17,
    parameter int AW = 37,
    parameter int FRAC_BITS = qoa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   issue,
    input  logic signed [MW-1:0]   op_a,
    input  logic signed [MW-1:0]   op_b,
    input  qoa_pkg::mac_tag_t      tag,
    output qoa_pkg::mac_stat_t     stat,
    output logic signed [AW-1:0]   sum
);
    import qoa_pkg::*;

    localparam logic signed [AW-1:0] ONE_SQ = {{(AW-1){1'b0}}, 1'b1} <<< (2 * FRAC_BITS);

    logic signed [2*MW-1:0] prod_reg;
    mac_tag_t               tag_reg;
    logic                   v1_reg;
    logic signed [AW-1:0]   acc_reg;
    mac_stat_t              stat_reg;

    logic signed [AW-1:0] term;
    logic signed [AW-1:0] base;
    logic signed [AW-1:0] acc_next;

    always_comb
    begin
        term = AW'(prod_reg);
        if (tag_reg.shift2)
        begin
            term = term >>> 2;
        end
        if (tag_reg.dbl)
        begin
            term = term <<< 1;
        end
        if (tag_reg.neg)
        begin
            term = -term;
        end
        if (tag_reg.first)
        begin
            base = tag_reg.init_one ? ONE_SQ : '0;
        end
        else
        begin
            base = acc_reg;
        end
        acc_next = base + term;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            stat_reg <= '0;
        end
        else
        begin
            v1_reg         <= issue;
            stat_reg.done  <= v1_reg && tag_reg.last;
            stat_reg.phase_end <= tag_reg.phase_end;
            stat_reg.dst   <= tag_reg.dst;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            prod_reg <= op_a * op_b;
            tag_reg  <= tag;
        end
        if (v1_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat = stat_reg;
    assign sum  = acc_reg;

endmodule

// ===== src/quaternion_orientation_accumulator.sv =====
// Quaternion orientation accumulator: Hamilton product, normalize, rotation matrix.
// Steps in order: Hamilton product on the shared MAC, magnitudes, bit-length scan, shift, sum of
// squares on the shared MAC, square root, one divide per component and the matrix on the shared MAC;
// a zero-norm product skips from the magnitudes straight to the matrix.
// One transaction at a time: a new input is taken only after the previous result has been accepted.
// Reset (rst_n, asynchronous) loads the identity orientation and empties the block.
module quaternion_orientation_accumulator #(
    parameter int COMPONENT_BITS = qoa_pkg::COMP_BITS_DEFAULT,
    parameter int FRAC_BITS      = qoa_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             restart,
    input  logic signed [COMPONENT_BITS-1:0] in_w,
    input  logic signed [COMPONENT_BITS-1:0] in_x,
    input  logic signed [COMPONENT_BITS-1:0] in_y,
    input  logic signed [COMPONENT_BITS-1:0] in_z,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [COMPONENT_BITS-1:0] r0c0,
    output logic signed [COMPONENT_BITS-1:0] r1c0,
    output logic signed [COMPONENT_BITS-1:0] r2c0,
    output logic signed [COMPONENT_BITS-1:0] r0c1,
    output logic signed [COMPONENT_BITS-1:0] r1c1,
    output logic signed [COMPONENT_BITS-1:0] r2c1,
    output logic signed [COMPONENT_BITS-1:0] r0c2,
    output logic signed [COMPONENT_BITS-1:0] r1c2,
    output logic signed [COMPONENT_BITS-1:0] r2c2,
    output logic                             norm_zero
);
    import qoa_pkg::*;

    localparam int CB  = COMPONENT_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int MW  = (CB > 17) ? CB : 17;
    localparam int AW  = (2 * MW + 3 > 2 * FB + 3) ? 2 * MW + 3 : 2 * FB + 3;
    localparam int QB  = FB + 2;
    localparam int DW  = FB + 31;
    localparam int TW  = 32;
    localparam int RW  = 62;
    localparam int LW  = $clog2(CB + 1);
    localparam int CW  = $clog2(((QB > 18) ? QB : 18) + 1);
    localparam int QX  = ((QB > CB) ? QB : CB) + 1;
    localparam int SW  = 34;

    localparam logic signed [AW-1:0] SAT_HI = {{(AW-CB+1){1'b0}}, {(CB-1){1'b1}}};
    localparam logic signed [AW-1:0] SAT_LO = ~SAT_HI;
    localparam logic signed [AW-1:0] UNIT_W = {{(AW-1){1'b0}}, 1'b1};
    localparam logic signed [AW-1:0] ONE_W  = UNIT_W <<< FB;
    localparam logic signed [AW-1:0] PROD_HALF = UNIT_W <<< (FB - 3);
    localparam logic signed [AW-1:0] MAT_HALF  = UNIT_W <<< (FB - 1);
    localparam logic [QX-1:0]        QHI = {{(QX-CB+1){1'b0}}, {(CB-1){1'b1}}};

    typedef enum logic [3:0] {
        S_IDLE, S_PROD, S_MAG, S_LEN, S_SHIFT, S_SUMSQ, S_ROOT, S_DSET, S_DRUN, S_MAT, S_OUT
    } state_t;

    function automatic logic signed [CB-1:0] sat_comp(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] r;
        r = v;
        if (v > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO;
        end
        return r[CB-1:0];
    endfunction

    localparam logic signed [CB-1:0] ID_W = sat_comp(ONE_W);

    state_t                 state_reg;
    logic [CW-1:0]          cnt_reg;
    logic [1:0]             idx_reg;
    logic signed [CB-1:0]   a_reg [4];
    logic signed [CB-1:0]   b_reg [4];
    logic signed [CB-1:0]   n_reg [4];
    logic [CB-1:0]          mag_reg [4];
    logic [CB-1:0]          m_reg;
    logic [LW-1:0]          len_reg;
    logic [15:0]            u_reg [4];
    logic [RW-1:0]          rad_reg;
    logic [RW-1:0]          root_reg;
    logic [RW-1:0]          bit_reg;
    logic [TW-1:0]          t_reg;
    logic [TW:0]            rem_reg;
    logic [QB-1:0]          dq_reg;
    logic signed [CB-1:0]   mat_reg [9];
    logic                   zero_reg;

    logic                   issue;
    logic signed [MW-1:0]   op_a;
    logic signed [MW-1:0]   op_b;
    mac_tag_t               tag;
    mac_stat_t              stat;
    logic signed [AW-1:0]   mac_sum;

    qoa_mac #(
        .MW       (MW),
        .AW       (AW),
        .FRAC_BITS(FB)
    ) u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .issue(issue),
        .op_a (op_a),
        .op_b (op_b),
        .tag  (tag),
        .stat (stat),
        .sum  (mac_sum)
    );

    // Operand selection for the shared MAC
    logic [1:0] pk;
    logic [1:0] pj;
    logic [1:0] ia;
    logic [1:0] ib;
    logic       mneg;
    logic       mone;

    always_comb
    begin
        pk    = cnt_reg[3:2];
        pj    = cnt_reg[1:0];
        ia    = 2'd0;
        ib    = 2'd0;
        mneg  = 1'b0;
        mone  = 1'b0;
        issue = 1'b0;
        op_a  = '0;
        op_b  = '0;
        tag   = '0;
        unique case (cnt_reg[4:1])
            4'd0:    begin ia = cnt_reg[0] ? 2'd3 : 2'd2; ib = ia; mneg = 1'b1; mone = 1'b1; end
            4'd1:    begin ia = cnt_reg[0] ? 2'd0 : 2'd1; ib = cnt_reg[0] ? 2'd3 : 2'd2; end
            4'd2:
            begin
                ia = cnt_reg[0] ? 2'd0 : 2'd1;
                ib = cnt_reg[0] ? 2'd2 : 2'd3;
                mneg = cnt_reg[0];
            end
            4'd3:
            begin
                ia = cnt_reg[0] ? 2'd0 : 2'd1;
                ib = cnt_reg[0] ? 2'd3 : 2'd2;
                mneg = cnt_reg[0];
            end
            4'd4:    begin ia = cnt_reg[0] ? 2'd3 : 2'd1; ib = ia; mneg = 1'b1; mone = 1'b1; end
            4'd5:    begin ia = cnt_reg[0] ? 2'd0 : 2'd2; ib = cnt_reg[0] ? 2'd1 : 2'd3; end
            4'd6:    begin ia = cnt_reg[0] ? 2'd0 : 2'd1; ib = cnt_reg[0] ? 2'd2 : 2'd3; end
            4'd7:
            begin
                ia = cnt_reg[0] ? 2'd0 : 2'd2;
                ib = cnt_reg[0] ? 2'd1 : 2'd3;
                mneg = cnt_reg[0];
            end
            4'd8:    begin ia = cnt_reg[0] ? 2'd2 : 2'd1; ib = ia; mneg = 1'b1; mone = 1'b1; end
            default: begin ia = 2'd0; ib = 2'd0; end
        endcase

        case (state_reg)
            S_PROD:
            begin
                issue         = cnt_reg < CW'(16);
                op_a          = MW'(a_reg[pj]);
                op_b          = MW'(b_reg[pj ^ pk]);
                tag.first     = pj == 2'd0;
                tag.last      = pj == 2'd3;
                tag.phase_end = cnt_reg == CW'(15);
                tag.shift2    = 1'b1;
                tag.neg       = (pk == 2'd0) ? (pj != 2'd0) :
                                (pk == 2'd1) ? (pj == 2'd3) :
                                (pk == 2'd2) ? (pj == 2'd1) : (pj == 2'd2);
                tag.dst       = {2'b00, pk};
            end
            S_SUMSQ:
            begin
                issue         = cnt_reg < CW'(4);
                op_a          = MW'(u_reg[pj]);
                op_b          = MW'(u_reg[pj]);
                tag.first     = pj == 2'd0;
                tag.last      = pj == 2'd3;
                tag.phase_end = pj == 2'd3;
            end
            S_MAT:
            begin
                issue         = cnt_reg < CW'(18);
                op_a          = MW'(n_reg[ia]);
                op_b          = MW'(n_reg[ib]);
                tag.first     = !cnt_reg[0];
                tag.last      = cnt_reg[0];
                tag.phase_end = cnt_reg == CW'(17);
                tag.dbl       = 1'b1;
                tag.neg       = mneg;
                tag.init_one  = mone;
                tag.dst       = cnt_reg[4:1];
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    // Magnitudes and their maximum
    logic [CB-1:0] mag_next [4];
    logic [CB-1:0] max01;
    logic [CB-1:0] max23;
    logic [CB-1:0] max_next;
    logic          all_zero;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mag_next[i] = n_reg[i][CB-1] ? CB'(-n_reg[i]) : CB'(n_reg[i]);
        end
        max01    = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        max23    = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
        max_next = (max01 > max23) ? max01 : max23;
        all_zero = (n_reg[0] == '0) && (n_reg[1] == '0) && (n_reg[2] == '0) && (n_reg[3] == '0);
    end

    // Root step, divider setup and step, quotient saturation
    logic [RW:0]          root_try;
    logic                 root_ge;
    logic [DW-1:0]        dvd;
    logic [TW:0]          trial;
    logic                 div_ge;
    logic [QB-1:0]        q_final;
    logic [QX-1:0]        q_ext;
    logic signed [CB-1:0] q_sat;
    logic [CB+15:0]       u_wide [4];

    always_comb
    begin
        root_try = {1'b0, root_reg} + {1'b0, bit_reg};
        root_ge  = {1'b0, rad_reg} >= root_try;
        dvd      = (DW'(u_reg[idx_reg]) << (FB + 14)) + DW'(t_reg >> 1);
        trial    = {rem_reg[TW-1:0], dq_reg[QB-1]};
        div_ge   = trial >= {1'b0, t_reg};
        q_final  = {dq_reg[QB-2:0], div_ge};
        q_ext    = QX'(q_final);
        q_sat    = (q_ext > QHI) ? QHI[CB-1:0] : q_ext[CB-1:0];
        for (int i = 0; i < 4; i++)
        begin
            u_wide[i] = {mag_reg[i], 16'b0} >> len_reg;
        end
    end

    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_PROD;
            S_PROD:  if (stat.done && stat.phase_end) state_next = S_MAG;
            S_MAG:   state_next = all_zero ? S_MAT : S_LEN;
            S_LEN:   if (m_reg == '0) state_next = S_SHIFT;
            S_SHIFT: state_next = S_SUMSQ;
            S_SUMSQ: if (stat.done && stat.phase_end) state_next = S_ROOT;
            S_ROOT:  if (bit_reg == '0) state_next = S_DSET;
            S_DSET:  state_next = S_DRUN;
            S_DRUN:
            begin
                if (cnt_reg == CW'(QB - 1))
                begin
                    state_next = (idx_reg == 2'd3) ? S_MAT : S_DSET;
                end
            end
            S_MAT:   if (stat.done && stat.phase_end) state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            zero_reg  <= 1'b0;
            n_reg[0]  <= ID_W;
            n_reg[1]  <= '0;
            n_reg[2]  <= '0;
            n_reg[3]  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else if (issue || state_reg == S_DRUN)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg[0] <= in_w;
                        a_reg[1] <= in_x;
                        a_reg[2] <= in_y;
                        a_reg[3] <= in_z;
                        b_reg[0] <= restart ? ID_W : n_reg[0];
                        b_reg[1] <= restart ? '0 : n_reg[1];
                        b_reg[2] <= restart ? '0 : n_reg[2];
                        b_reg[3] <= restart ? '0 : n_reg[3];
                    end
                end
                S_PROD:
                begin
                    if (stat.done)
                    begin
                        n_reg[stat.dst[1:0]] <=
                            sat_comp((mac_sum + PROD_HALF) >>> (FB - 2));
                    end
                end
                S_MAG:
                begin
                    zero_reg <= all_zero;
                    mag_reg  <= mag_next;
                    m_reg    <= max_next;
                    len_reg  <= '0;
                end
                S_LEN:
                begin
                    if (m_reg != '0)
                    begin
                        m_reg   <= m_reg >> 1;
                        len_reg <= len_reg + LW'(1);
                    end
                end
                S_SHIFT:
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        u_reg[i] <= u_wide[i][15:0];
                    end
                end
                S_SUMSQ:
                begin
                    if (stat.done)
                    begin
                        rad_reg  <= RW'(mac_sum[SW-1:0]) << 28;
                        root_reg <= '0;
                        bit_reg  <= RW'(1) << (RW - 2);
                    end
                end
                S_ROOT:
                begin
                    if (bit_reg != '0)
                    begin
                        if (root_ge)
                        begin
                            rad_reg  <= rad_reg - root_try[RW-1:0];
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                        begin
                            root_reg <= root_reg >> 1;
                        end
                        bit_reg <= bit_reg >> 2;
                    end
                    else
                    begin
                        t_reg   <= root_reg[TW-1:0];
                        idx_reg <= 2'd0;
                    end
                end
                S_DSET:
                begin
                    rem_reg <= (TW + 1)'(dvd >> QB);
                    dq_reg  <= dvd[QB-1:0];
                end
                S_DRUN:
                begin
                    rem_reg <= div_ge ? (trial - {1'b0, t_reg}) : trial;
                    dq_reg  <= q_final;
                    if (cnt_reg == CW'(QB - 1))
                    begin
                        // keep the sign of the product, saturated magnitude
                        n_reg[idx_reg] <= n_reg[idx_reg][CB-1] ? -q_sat : q_sat;
                        idx_reg        <= idx_reg + 2'd1;
                    end
                end
                S_MAT:
                begin
                    if (stat.done)
                    begin
                        mat_reg[stat.dst] <= sat_comp((mac_sum + MAT_HALF) >>> FB);
                    end
                end
                S_OUT:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = state_reg == S_OUT;
    assign r0c0      = mat_reg[0];
    assign r1c0      = mat_reg[1];
    assign r2c0      = mat_reg[2];
    assign r0c1      = mat_reg[3];
    assign r1c1      = mat_reg[4];
    assign r2c1      = mat_reg[5];
    assign r0c2      = mat_reg[6];
    assign r1c2      = mat_reg[7];
    assign r2c2      = mat_reg[8];
    assign norm_zero = zero_reg;

    // A finished result blocks new transactions
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input accepted while a result waits");

    // MAC sums land only in the phases that consume them
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_PROD || state_reg == S_SUMSQ || state_reg == S_MAT))
        else $error("MAC result outside an accumulate phase");

    // A result appears only after the matrix phase
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_MAT))
        else $error("result raised without a matrix pass");

    // A nonzero product always yields a nonzero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRUN) |-> (t_reg != '0))
        else $error("zero divisor in normalize");

endmodule
